/* rtl/lkv_pkg.sv */
package lkv_pkg;

    localparam int LKV_ENTRIES    = 16;
    localparam int LKV_KEY_BITS   = 32;
    localparam int LKV_VALUE_BITS = 32;

    typedef enum logic
    {
        OP_LOOKUP = 1'b0,
        OP_INSERT = 1'b1
    } lkv_op_t;

    typedef struct packed
    {
        logic hit;
        logic full;
    } lkv_status_t;

endpackage

/* rtl/lkv_lookup.sv */
module lkv_lookup
    import lkv_pkg::*;
#(
    parameter int ENTRIES    = LKV_ENTRIES,
    parameter int KEY_BITS   = LKV_KEY_BITS,
    parameter int RANK_BITS  = $clog2(LKV_ENTRIES)
)
(
    input  logic [KEY_BITS-1:0]  key,
    input  logic [ENTRIES-1:0]   entry_valid,
    input  logic [KEY_BITS-1:0]  entry_key [ENTRIES],
    input  logic [RANK_BITS-1:0] entry_rank [ENTRIES],
    output lkv_status_t          status,
    output logic [ENTRIES-1:0]   slot_sel
);

    localparam logic [RANK_BITS-1:0] OLDEST = RANK_BITS'(ENTRIES - 1);

    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] match_oh;
    logic [ENTRIES-1:0] oldest;
    logic [ENTRIES-1:0] victim_oh;
    logic [ENTRIES-1:0] free_vec;
    logic [ENTRIES-1:0] free_oh;

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i]  = entry_valid[i] && (entry_key[i] == key);
            oldest[i] = entry_valid[i] && (entry_rank[i] == OLDEST);
        end
    end

    // lowest set bit of each candidate vector
    assign free_vec  = ~entry_valid;
    assign free_oh   = free_vec & (~free_vec + ENTRIES'(1));
    assign match_oh  = match & (~match + ENTRIES'(1));
    assign victim_oh = oldest & (~oldest + ENTRIES'(1));

    assign status.hit  = |match;
    assign status.full = &entry_valid;

    always_comb
    begin
        if (status.hit)
        begin
            slot_sel = match_oh;
        end
        else if (status.full)
        begin
            slot_sel = victim_oh;
        end
        else
        begin
            slot_sel = free_oh;
        end
    end

endmodule

/* rtl/lkv_store.sv */
module lkv_store
    import lkv_pkg::*;
#(
    parameter int ENTRIES    = LKV_ENTRIES,
    parameter int KEY_BITS   = LKV_KEY_BITS,
    parameter int VALUE_BITS = LKV_VALUE_BITS,
    parameter int RANK_BITS  = $clog2(LKV_ENTRIES)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  update,
    input  lkv_op_t               op,
    input  logic [KEY_BITS-1:0]   key,
    input  logic [VALUE_BITS-1:0] value,
    input  lkv_status_t           status,
    input  logic [ENTRIES-1:0]    slot_sel,
    output logic [ENTRIES-1:0]    entry_valid,
    output logic [KEY_BITS-1:0]   entry_key [ENTRIES],
    output logic [RANK_BITS-1:0]  entry_rank [ENTRIES],
    output logic [KEY_BITS-1:0]   rd_key,
    output logic [VALUE_BITS-1:0] rd_value
);

    localparam logic [RANK_BITS-1:0] OLDEST = RANK_BITS'(ENTRIES - 1);

    logic [ENTRIES-1:0]    valid_reg;
    logic [ENTRIES-1:0]    valid_next;
    logic [KEY_BITS-1:0]   key_reg [ENTRIES];
    logic [VALUE_BITS-1:0] value_reg [ENTRIES];
    logic [RANK_BITS-1:0]  rank_reg [ENTRIES];
    logic [RANK_BITS-1:0]  rank_next [ENTRIES];
    logic [RANK_BITS-1:0]  ref_rank;
    logic                  write;
    logic                  insert;

    assign insert = (op == OP_INSERT);
    assign write  = update && (status.hit || insert);

    // a new key is placed as a touch of a slot ranked oldest
    always_comb
    begin
        ref_rank = status.hit ? OLDEST : OLDEST;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (status.hit && slot_sel[i])
            begin
                ref_rank = rank_reg[i];
            end
        end
    end

    always_comb
    begin
        rd_key   = '0;
        rd_value = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            rd_key   = rd_key | (key_reg[i] & {KEY_BITS{slot_sel[i]}});
            rd_value = rd_value | (value_reg[i] & {VALUE_BITS{slot_sel[i]}});
        end
    end

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            valid_next[i] = valid_reg[i];
            rank_next[i]  = rank_reg[i];
            if (write)
            begin
                if (slot_sel[i])
                begin
                    rank_next[i] = '0;
                    if (insert)
                    begin
                        valid_next[i] = 1'b1;
                    end
                end
                else if (valid_reg[i] && (rank_reg[i] < ref_rank))
                begin
                    rank_next[i] = rank_reg[i] + RANK_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (write && insert && slot_sel[i])
            begin
                value_reg[i] <= value;
                if (!status.hit)
                begin
                    key_reg[i] <= key;
                end
            end
        end
    end

    assign entry_valid = valid_reg;
    assign entry_key   = key_reg;
    assign entry_rank  = rank_reg;

endmodule

/* rtl/lru_key_value_cache.sv */
// channel   valid      stall      payload
// req       req_valid  req_stall  op, key, value
// rsp       rsp_valid  rsp_stall  hit, value_out, evicted, evicted_key
//
// One request per cycle while req_stall is low; each request is held first
// in the input register, then the parallel tag compare and rank update
// land the result in the response register.
// Reset empties the store and clears all ranks; keys and values are not reset.
// A stalled response holds the input register; req_stall rises only when both are full.
module lru_key_value_cache
    import lkv_pkg::*;
#(
    parameter int ENTRIES    = LKV_ENTRIES,
    parameter int KEY_BITS   = LKV_KEY_BITS,
    parameter int VALUE_BITS = LKV_VALUE_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic                  op,
    input  logic [KEY_BITS-1:0]   key,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output logic                  hit,
    output logic [VALUE_BITS-1:0] value_out,
    output logic                  evicted,
    output logic [KEY_BITS-1:0]   evicted_key
);

    localparam int RANK_BITS = $clog2(ENTRIES);

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    lkv_op_t               s1_op_reg;
    logic [KEY_BITS-1:0]   s1_key_reg;
    logic [VALUE_BITS-1:0] s1_value_reg;

    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;
    logic                  hit_reg;
    logic                  hit_next;
    logic [VALUE_BITS-1:0] value_out_reg;
    logic [VALUE_BITS-1:0] value_out_next;
    logic                  evicted_reg;
    logic                  evicted_next;
    logic [KEY_BITS-1:0]   evicted_key_reg;
    logic [KEY_BITS-1:0]   evicted_key_next;

    logic                  advance;
    logic                  fire;
    lkv_status_t           status;
    logic [ENTRIES-1:0]    slot_sel;
    logic [ENTRIES-1:0]    entry_valid;
    logic [KEY_BITS-1:0]   entry_key [ENTRIES];
    logic [RANK_BITS-1:0]  entry_rank [ENTRIES];
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_value;

    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign fire      = s1_valid_reg && advance;
    assign req_stall = s1_valid_reg && !advance;

    lkv_lookup #(
        .ENTRIES   (ENTRIES),
        .KEY_BITS  (KEY_BITS),
        .RANK_BITS (RANK_BITS)
    ) u_lookup (
        .key         (s1_key_reg),
        .entry_valid (entry_valid),
        .entry_key   (entry_key),
        .entry_rank  (entry_rank),
        .status      (status),
        .slot_sel    (slot_sel)
    );

    lkv_store #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS),
        .RANK_BITS  (RANK_BITS)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .update      (fire),
        .op          (s1_op_reg),
        .key         (s1_key_reg),
        .value       (s1_value_reg),
        .status      (status),
        .slot_sel    (slot_sel),
        .entry_valid (entry_valid),
        .entry_key   (entry_key),
        .entry_rank  (entry_rank),
        .rd_key      (rd_key),
        .rd_value    (rd_value)
    );

    always_comb
    begin
        s1_valid_next = req_stall ? s1_valid_reg : req_valid;

        if (fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg && rsp_stall;
        end

        hit_next         = status.hit;
        value_out_next   = (s1_op_reg == OP_LOOKUP && status.hit) ? rd_value : '0;
        evicted_next     = (s1_op_reg == OP_INSERT) && !status.hit && status.full;
        evicted_key_next = evicted_next ? rd_key : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!req_stall)
        begin
            s1_op_reg    <= lkv_op_t'(op);
            s1_key_reg   <= key;
            s1_value_reg <= value;
        end
        if (fire)
        begin
            hit_reg         <= hit_next;
            value_out_reg   <= value_out_next;
            evicted_reg     <= evicted_next;
            evicted_key_reg <= evicted_key_next;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign hit         = hit_reg;
    assign value_out   = value_out_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = evicted_key_reg;

    // exactly one slot chosen: catches broken ranks (a full store with no entry ranked oldest)
    a_slot_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> $onehot(slot_sel))
        else $error("slot select not one-hot");

    a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(evicted_reg && hit_reg))
        else $error("eviction reported on a hit");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (s1_valid_reg && rsp_valid_reg && rsp_stall))
        else $error("request stalled with room in the pipeline");

    a_store_grows: assert property (@(posedge clk) disable iff (!rst_n)
        fire && s1_op_reg == OP_INSERT && !status.hit && !status.full
        |=> $countones(entry_valid) == $countones($past(entry_valid)) + 1)
        else $error("insert into free slot did not fill it");

endmodule

/* bench/lkv_response_checker.sv */
`timescale 1ns / 1ps

module lkv_response_checker
    import lkv_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    input  logic                      req_stall,
    input  logic                      op,
    input  logic [LKV_KEY_BITS-1:0]   key,
    input  logic [LKV_VALUE_BITS-1:0] value,
    input  logic                      rsp_valid,
    input  logic                      rsp_stall,
    input  logic                      hit,
    input  logic [LKV_VALUE_BITS-1:0] value_out,
    input  logic                      evicted,
    input  logic [LKV_KEY_BITS-1:0]   evicted_key,
    output int                        errors,
    output int                        outstanding
);

    typedef struct packed
    {
        logic                      hit;
        logic [LKV_VALUE_BITS-1:0] value_out;
        logic                      evicted;
        logic [LKV_KEY_BITS-1:0]   evicted_key;
    } cache_rsp_t;

    logic                      slot_live [LKV_ENTRIES];
    logic [LKV_KEY_BITS-1:0]   slot_key  [LKV_ENTRIES];
    logic [LKV_VALUE_BITS-1:0] slot_val  [LKV_ENTRIES];
    int unsigned               slot_age  [LKV_ENTRIES];

    cache_rsp_t due_responses [$];

    initial
    begin
        errors      = 0;
        outstanding = 0;
    end

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        errors++;
    endtask

    function automatic void clear_store();
        for (int i = 0; i < LKV_ENTRIES; i++)
        begin
            slot_live[i] = 1'b0;
            slot_key[i]  = '0;
            slot_val[i]  = '0;
            slot_age[i]  = 0;
        end
    endfunction

    function automatic void promote_slot(input int s);
        int unsigned r;
        r = slot_age[s];
        for (int i = 0; i < LKV_ENTRIES; i++)
        begin
            if (i != s && slot_live[i] && slot_age[i] < r)
                slot_age[i] = slot_age[i] + 1;
        end
        slot_age[s] = 0;
    endfunction

    // Applies one request to the shadow store and returns the response it should give.
    function automatic cache_rsp_t cache_access(input logic o,
                                                input logic [LKV_KEY_BITS-1:0] k,
                                                input logic [LKV_VALUE_BITS-1:0] v);
        cache_rsp_t r;
        int         s;
        int         free_slot;
        r         = '0;
        s         = -1;
        free_slot = -1;
        for (int i = 0; i < LKV_ENTRIES; i++)
        begin
            if (s < 0 && slot_live[i] && slot_key[i] == k)
                s = i;
        end
        if (o == OP_LOOKUP)
        begin
            if (s >= 0)
            begin
                r.hit       = 1'b1;
                r.value_out = slot_val[s];
                promote_slot(s);
            end
        end
        else if (s >= 0)
        begin
            r.hit       = 1'b1;
            slot_val[s] = v;
            promote_slot(s);
        end
        else
        begin
            for (int i = 0; i < LKV_ENTRIES; i++)
            begin
                if (free_slot < 0 && !slot_live[i])
                    free_slot = i;
            end
            if (free_slot >= 0)
            begin
                for (int i = 0; i < LKV_ENTRIES; i++)
                begin
                    if (slot_live[i])
                        slot_age[i] = slot_age[i] + 1;
                end
                s = free_slot;
            end
            else
            begin
                s = 0;
                for (int i = 1; i < LKV_ENTRIES; i++)
                begin
                    if (slot_age[i] > slot_age[s])
                        s = i;
                end
                r.evicted     = 1'b1;
                r.evicted_key = slot_key[s];
                promote_slot(s);
            end
            slot_live[s] = 1'b1;
            slot_key[s]  = k;
            slot_val[s]  = v;
            slot_age[s]  = 0;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cache_rsp_t want;
        if (!rst_n)
        begin
            clear_store();
            due_responses.delete();
            outstanding <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                due_responses.push_back(cache_access(op, key, value));
            if (rsp_valid && !rsp_stall)
            begin
                if (due_responses.size() == 0)
                    report_mismatch("response transfer with none outstanding");
                else
                begin
                    want = due_responses.pop_front();
                    if (hit !== want.hit)
                        report_mismatch($sformatf("hit %b, want %b", hit, want.hit));
                    if (value_out !== want.value_out)
                        report_mismatch($sformatf("value_out %h, want %h",
                                                  value_out, want.value_out));
                    if (evicted !== want.evicted)
                        report_mismatch($sformatf("evicted %b, want %b",
                                                  evicted, want.evicted));
                    if (evicted_key !== want.evicted_key)
                        report_mismatch($sformatf("evicted_key %h, want %h",
                                                  evicted_key, want.evicted_key));
                end
            end
            outstanding <= due_responses.size();
        end
    end

endmodule

/* bench/lru_key_value_cache_tb.sv */
`timescale 1ns / 1ps

module lru_key_value_cache_tb;
    import lkv_pkg::*;

    localparam int RANDOM_ITEMS = 400;

    logic                      clk;
    logic                      rst_n;
    logic                      req_valid;
    logic                      req_stall;
    logic                      op;
    logic [LKV_KEY_BITS-1:0]   key;
    logic [LKV_VALUE_BITS-1:0] value;
    logic                      rsp_valid;
    logic                      rsp_stall;
    logic                      hit;
    logic [LKV_VALUE_BITS-1:0] value_out;
    logic                      evicted;
    logic [LKV_KEY_BITS-1:0]   evicted_key;
    int                        errors;
    int                        outstanding;
    logic [LKV_KEY_BITS-1:0]   key_pool [24];
    bit                        no_gaps;

    lru_key_value_cache uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .op          (op),
        .key         (key),
        .value       (value),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .hit         (hit),
        .value_out   (value_out),
        .evicted     (evicted),
        .evicted_key (evicted_key)
    );

    lkv_response_checker checker_i
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .op          (op),
        .key         (key),
        .value       (value),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .hit         (hit),
        .value_out   (value_out),
        .evicted     (evicted),
        .evicted_key (evicted_key),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 20);
    endfunction

    // Call just after a rising edge; returns after the rising edge of the transfer.
    task automatic issue_request(input lkv_op_t o,
                                 input logic [LKV_KEY_BITS-1:0] k,
                                 input logic [LKV_VALUE_BITS-1:0] v);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        op        <= o;
        key       <= k;
        value     <= v;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // Response back-pressure: runs of free cycles and stalls, now and then long free stretches.
    initial
    begin
        int run;
        rsp_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 8);
            repeat (run)
            begin
                @(negedge clk);
                rsp_stall <= 1'b0;
            end
            run = $urandom_range(0, 99);
            run = (run < 70) ? $urandom_range(1, 2) :
                  (run < 95) ? $urandom_range(3, 6) : $urandom_range(10, 30);
            repeat (run)
            begin
                @(negedge clk);
                rsp_stall <= 1'b1;
            end
        end
    end

    initial
    begin
        lkv_op_t o;
        logic [LKV_KEY_BITS-1:0] k;
        int span;

        req_valid = 1'b0;
        op        = OP_LOOKUP;
        key       = '0;
        value     = '0;
        no_gaps   = 1'b0;
        rst_n     = 1'b0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < 24; i++)
            key_pool[i] = $urandom;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store, extreme keys and values, update in place, miss
        issue_request(OP_LOOKUP, '0, '1);
        issue_request(OP_INSERT, '0, '0);
        issue_request(OP_INSERT, '1, '1);
        issue_request(OP_LOOKUP, '0, $urandom);
        issue_request(OP_LOOKUP, '1, '0);
        issue_request(OP_INSERT, '0, 32'ha5a5_a5a5);
        issue_request(OP_LOOKUP, '0, '0);
        issue_request(OP_LOOKUP, 32'h1234_5678, '1);
        // fill the store, then overflow it
        for (int i = 0; i < 14; i++)
            issue_request(OP_INSERT, 32'h0000_0100 + i, $urandom);
        issue_request(OP_INSERT, 32'hdead_beef, 32'h5a5a_5a5a);
        issue_request(OP_LOOKUP, '1, '0);
        issue_request(OP_LOOKUP, '0, '0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            no_gaps = ((n / 50) % 3 == 1);
            span    = (n < RANDOM_ITEMS / 2) ? 11 : 23;
            o       = $urandom_range(0, 1) ? OP_INSERT : OP_LOOKUP;
            k       = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, span)];
            issue_request(o, k, $urandom);
        end
        no_gaps = 1'b0;

        @(negedge clk);
        req_valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
